// ----- hdl/tsra_pkg.sv -----
// Shared types and constants for the time slot ring accumulator.
package tsra_pkg;

   // Field widths fixed by the request and result formats.
   localparam int SLOT_W     = 6;   // slot number, enough for the largest ring
   localparam int NEURON_W   = 6;   // neuron number
   localparam int CSR_DATA_W = 7;   // widest configuration register
   localparam int ADDR_CALC_W = 12; // slot * neurons + neuron at the largest size
   localparam int OPQ_DEPTH  = 4;   // decoded operations between front and back
   localparam int RSPQ_DEPTH = 4;   // finished results waiting to be popped

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_TICK  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_NEURON = 2'd1,
      ST_BAD_OFFSET = 2'd2
   } status_type;

   typedef enum logic {
      CSR_SLOTS   = 1'b0,
      CSR_NEURONS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_ADD,
      OP_READ,
      OP_TICK,
      OP_REJECT
   } op_kind_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_WAIT,
      BK_TICK_RD
   } back_state_type;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [NEURON_W-1:0]      neuron_index;
      logic [3:0]               slot_offset;
      logic signed [31:0]       value_in;
   } req_type;

   typedef struct packed {
      logic [NEURON_W-1:0]      neuron_out;
      logic signed [31:0]       value_out;
      logic                     last_out;
      logic [1:0]               status_out;
   } rsp_type;

   // One decoded operation. For a tick, neuron holds the last neuron to drain.
   typedef struct packed {
      op_kind_type              kind;
      logic [1:0]               status;
      logic [SLOT_W-1:0]        slot;
      logic [NEURON_W-1:0]      neuron;
      logic signed [31:0]       value;
   } op_type;

endpackage

// ----- hdl/tsra_fifo.sv -----
// Small first-in first-out queue used between the stages.
module tsra_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/tsra_sat.sv -----
// Signed saturation from one width to another.
module tsra_sat #(
   parameter int IN_W  = 33,
   parameter int OUT_W = 32
) (
   input  logic signed [IN_W-1:0]  din,
   output logic signed [OUT_W-1:0] dout
);

   generate
      if (OUT_W >= IN_W) begin : g_extend
         assign dout = OUT_W'(din);
      end else begin : g_clip
         logic fits;
         // The value fits when every bit above the new sign bit copies it.
         assign fits = (&din[IN_W-1:OUT_W-1]) | ~(|din[IN_W-1:OUT_W-1]);
         assign dout = fits        ? din[OUT_W-1:0] :
                       din[IN_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} :
                                     {1'b0, {(OUT_W-1){1'b1}}};
      end
   endgenerate

endmodule

// ----- hdl/tsra_front.sv -----
// Front end: configuration registers, slot pointer and request decoding.
module tsra_front
   import tsra_pkg::*;
#(
   parameter int MAX_SLOTS   = 16,
   parameter int MAX_NEURONS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   input  logic                  clear_busy,
   input  logic                  op_full,
   output logic                  op_push,
   output op_type                op_data
);

   logic [4:0]        slots_cfg_ff;
   logic [6:0]        neurons_cfg_ff;
   logic [SLOT_W-1:0] raw_ptr_ff, raw_ptr_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic              reduce_ff, reduce_in;
   logic [6:0]        eff_slots, eff_neurons;
   logic [6:0]        off_sum, tick_next;
   logic              accept, idx_bad, off_bad;

   always_comb begin
      if (slots_cfg_ff == '0) begin
         eff_slots = 7'd1;
      end else if (7'(slots_cfg_ff) > 7'(MAX_SLOTS)) begin
         eff_slots = 7'(MAX_SLOTS);
      end else begin
         eff_slots = 7'(slots_cfg_ff);
      end
      if (neurons_cfg_ff == '0) begin
         eff_neurons = 7'd1;
      end else if (neurons_cfg_ff > 7'(MAX_NEURONS)) begin
         eff_neurons = 7'(MAX_NEURONS);
      end else begin
         eff_neurons = neurons_cfg_ff;
      end
   end

   assign req_full = reduce_ff || clear_busy || op_full;
   assign accept   = req_push && !req_full;
   assign op_push  = accept;

   assign idx_bad   = (7'(req_data.neuron_index) >= eff_neurons);
   assign off_bad   = (7'(req_data.slot_offset) >= eff_slots);
   assign off_sum   = 7'(cur_ff) + 7'(req_data.slot_offset);
   assign tick_next = 7'(cur_ff) + 7'd1;

   always_comb begin
      op_data.kind   = OP_REJECT;
      op_data.status = ST_OK;
      op_data.slot   = cur_ff;
      op_data.neuron = req_data.neuron_index;
      op_data.value  = req_data.value_in;
      if (req_data.cmd == CMD_TICK) begin
         op_data.kind   = OP_TICK;
         op_data.neuron = NEURON_W'(eff_neurons - 7'd1);
      end else if (idx_bad) begin
         op_data.status = ST_BAD_NEURON;
      end else if (req_data.cmd == CMD_READ) begin
         op_data.kind = OP_READ;
      end else if (off_bad) begin
         op_data.status = ST_BAD_OFFSET;
      end else begin
         op_data.kind = (req_data.cmd == CMD_ADD) ? OP_ADD : OP_WRITE;
         op_data.slot = (off_sum >= eff_slots) ? SLOT_W'(off_sum - eff_slots)
                                               : SLOT_W'(off_sum);
      end
   end

   // The working pointer is the raw pointer reduced modulo the ring size. It is
   // rebuilt by repeated subtraction after every configuration write.
   always_comb begin
      raw_ptr_in = raw_ptr_ff;
      cur_in     = cur_ff;
      reduce_in  = reduce_ff;
      if (csr_write_en) begin
         cur_in    = raw_ptr_ff;
         reduce_in = 1'b1;
      end else if (reduce_ff) begin
         if (7'(cur_ff) >= eff_slots) begin
            cur_in = SLOT_W'(7'(cur_ff) - eff_slots);
         end else begin
            reduce_in = 1'b0;
         end
      end else if (accept && (req_data.cmd == CMD_TICK)) begin
         cur_in     = (tick_next >= eff_slots) ? '0 : SLOT_W'(tick_next);
         raw_ptr_in = cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_cfg_ff   <= 5'd16;
         neurons_cfg_ff <= 7'd16;
         raw_ptr_ff     <= '0;
         cur_ff         <= '0;
         reduce_ff      <= 1'b0;
      end else begin
         raw_ptr_ff <= raw_ptr_in;
         cur_ff     <= cur_in;
         reduce_ff  <= reduce_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_SLOTS:   slots_cfg_ff   <= csr_wdata[4:0];
               CSR_NEURONS: neurons_cfg_ff <= csr_wdata;
               default:     slots_cfg_ff   <= slots_cfg_ff;
            endcase
         end
      end
   end

endmodule

// ----- hdl/tsra_back.sv -----
// Back end: slot store memory and the sequencer that carries out operations.
module tsra_back
   import tsra_pkg::*;
#(
   parameter int MAX_SLOTS   = 16,
   parameter int MAX_NEURONS = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    op_empty,
   input  op_type  op_data,
   output logic    op_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_out,
   output logic    clear_busy
);

   localparam int DEPTH = MAX_SLOTS * MAX_NEURONS;
   localparam int AW    = $clog2(DEPTH);
   localparam int VW    = VALUE_WIDTH;

   logic signed [VW-1:0] mem [DEPTH];

   back_state_type       state_ff, state_in;
   op_type               op_ff, op_in;
   logic [NEURON_W-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic signed [VW-1:0] rd_data_ff;

   logic [SLOT_W-1:0]    addr_slot;
   logic [NEURON_W-1:0]  addr_neuron;
   logic [AW-1:0]        calc_addr, mem_addr;
   logic                 mem_we, mem_re;
   logic signed [VW-1:0] mem_wdata;

   logic signed [VW-1:0] vin_c, sum_c, emit_src;
   logic signed [VW:0]   sum_w;
   logic signed [31:0]   emit_val;
   logic                 tick_last;

   assign clear_busy = (state_ff == BK_CLEAR);
   assign tick_last  = (cnt_ff == op_ff.neuron);

   tsra_sat #(.IN_W(32), .OUT_W(VW)) u_sat_in (
      .din  (op_ff.value),
      .dout (vin_c)
   );

   assign sum_w = (VW + 1)'(rd_data_ff) + (VW + 1)'(vin_c);

   tsra_sat #(.IN_W(VW + 1), .OUT_W(VW)) u_sat_sum (
      .din  (sum_w),
      .dout (sum_c)
   );

   always_comb begin
      case (op_ff.kind)
         OP_WRITE: emit_src = vin_c;
         OP_ADD:   emit_src = sum_c;
         default:  emit_src = rd_data_ff;
      endcase
   end

   tsra_sat #(.IN_W(VW), .OUT_W(32)) u_sat_out (
      .din  (emit_src),
      .dout (emit_val)
   );

   always_comb begin
      addr_slot   = op_ff.slot;
      addr_neuron = op_ff.neuron;
      case (state_ff)
         BK_IDLE: begin
            addr_slot   = op_data.slot;
            addr_neuron = (op_data.kind == OP_TICK) ? '0 : op_data.neuron;
         end
         BK_WAIT: begin
            addr_neuron = (op_ff.kind == OP_TICK) ? cnt_ff : op_ff.neuron;
         end
         BK_TICK_RD: begin
            addr_neuron = cnt_ff + 1'b1;
         end
         default: begin
            addr_neuron = op_ff.neuron;
         end
      endcase
   end

   assign calc_addr = AW'(ADDR_CALC_W'(addr_slot) * ADDR_CALC_W'(MAX_NEURONS)
                          + ADDR_CALC_W'(addr_neuron));

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cnt_in     = cnt_ff;
      clr_cnt_in = clr_cnt_ff;
      op_pop     = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_wdata  = '0;
      mem_addr   = calc_addr;
      rsp_push   = 1'b0;
      rsp_out    = '0;
      case (state_ff)
         BK_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (!op_empty && !rsp_full) begin
               op_pop = 1'b1;
               op_in  = op_data;
               if (op_data.kind == OP_REJECT) begin
                  rsp_push           = 1'b1;
                  rsp_out.neuron_out = op_data.neuron;
                  rsp_out.last_out   = 1'b1;
                  rsp_out.status_out = op_data.status;
               end else begin
                  mem_re   = 1'b1;
                  cnt_in   = '0;
                  state_in = BK_WAIT;
               end
            end
         end
         BK_WAIT: begin
            rsp_push           = 1'b1;
            rsp_out.value_out  = emit_val;
            rsp_out.status_out = ST_OK;
            rsp_out.neuron_out = (op_ff.kind == OP_TICK) ? cnt_ff : op_ff.neuron;
            rsp_out.last_out   = (op_ff.kind != OP_TICK) || tick_last;
            case (op_ff.kind)
               OP_WRITE: begin
                  mem_we    = 1'b1;
                  mem_wdata = vin_c;
               end
               OP_ADD: begin
                  mem_we    = 1'b1;
                  mem_wdata = sum_c;
               end
               OP_TICK: begin
                  mem_we = 1'b1;
               end
               default: begin
                  mem_we = 1'b0;
               end
            endcase
            if ((op_ff.kind == OP_TICK) && !tick_last) begin
               state_in = BK_TICK_RD;
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_TICK_RD: begin
            if (!rsp_full) begin
               cnt_in   = cnt_ff + 1'b1;
               mem_re   = 1'b1;
               state_in = BK_WAIT;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

endmodule

// ----- hdl/time_slot_ring_accumulator.sv -----
// Top level of the time slot ring accumulator.
//
//   Channel   Ports                                 Direction  Moves
//   request   req_push, req_full, req_data          in         one command
//   result    rsp_pop, rsp_empty, rsp_data          out        one result
//   csr       csr_write_en, csr_index, csr_wdata    in         one register write
//
// A rejected request is answered from the idle state of the back end; a write,
// add or read takes one memory read, then one write or result; and a tick reads,
// emits and clears each neuron in use in turn, set by the single-port slot store.
// After reset the slot store is cleared, during which req_full stays high. After
// any register write the slot pointer is reduced modulo the ring size, with
// req_full high until that is done.
// The front end keeps accepting requests while the back end or the result
// queue stalls, until the operation queue fills.
module time_slot_ring_accumulator
   import tsra_pkg::*;
#(
   parameter int MAX_SLOTS   = 16,
   parameter int MAX_NEURONS = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int OP_W  = $bits(op_type);
   localparam int RSP_W = $bits(rsp_type);

   // Decoded operations travel from the front end to the back end here.
   op_type           front_op;
   logic             opq_push, opq_full, opq_empty, opq_pop;
   logic [OP_W-1:0]  opq_out;
   op_type           back_op;

   // Finished results wait here until the consumer pops them.
   rsp_type          back_rsp;
   logic             rspq_push, rspq_full;
   logic [RSP_W-1:0] rspq_out;

   logic             clear_busy;

   // The front end decodes each request against the current configuration
   // and the slot pointer, so errors and target slots are settled on entry.
   tsra_front #(
      .MAX_SLOTS   (MAX_SLOTS),
      .MAX_NEURONS (MAX_NEURONS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .clear_busy   (clear_busy),
      .op_full      (opq_full),
      .op_push      (opq_push),
      .op_data      (front_op)
   );

   tsra_fifo #(
      .WIDTH (OP_W),
      .DEPTH (OPQ_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (opq_push),
      .push_data (front_op),
      .full      (opq_full),
      .pop       (opq_pop),
      .pop_data  (opq_out),
      .empty     (opq_empty)
   );

   assign back_op = op_type'(opq_out);

   // The back end owns the slot store and produces every result in order.
   tsra_back #(
      .MAX_SLOTS   (MAX_SLOTS),
      .MAX_NEURONS (MAX_NEURONS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_empty   (opq_empty),
      .op_data    (back_op),
      .op_pop     (opq_pop),
      .rsp_full   (rspq_full),
      .rsp_push   (rspq_push),
      .rsp_out    (back_rsp),
      .clear_busy (clear_busy)
   );

   tsra_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSPQ_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rspq_push),
      .push_data (back_rsp),
      .full      (rspq_full),
      .pop       (rsp_pop),
      .pop_data  (rspq_out),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_type'(rspq_out);

endmodule

// ----- tb/time_slot_ring_accumulator_test.sv -----
// Self-checking testbench for the time slot ring accumulator: directed and random requests.
module time_slot_ring_accumulator_test;
   import tsra_pkg::*;

   // The block is built at its default size, and the predictor mirrors that size.
   localparam int RING_SLOTS   = 16;
   localparam int RING_NEURONS = 16;
   localparam int CLOCK_PERIOD = 12;
   // This margin is waited out once at the very end.
   localparam int SETTLE_CYCLES = 80;
   // The slowest correct run is about 100 requests of 16 results each, with every
   // result held up by the longest stall the result side draws, and this guard is
   // roughly twenty times that.
   localparam int GUARD_CYCLES = 400_000;
   localparam int RANDOM_PER_PHASE = 16;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   req_type               req_data;
   logic                  rsp_empty;
   logic                  rsp_pop;
   rsp_type               rsp_data;
   logic                  csr_write_en;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // This is the predictor's own copy of the ring, the pointer and the two registers.
   // The raw register values are kept, and the clamping is applied when they are used.
   logic signed [31:0]    slot_value [RING_SLOTS][RING_NEURONS];
   int unsigned           ring_pos;
   logic [4:0]            slots_reg;
   logic [6:0]            neurons_reg;

   // These are the results still owed by the block, oldest first.
   rsp_type               owed_results [$];
   int                    error_count;
   bit                    idling_on;
   int                    pop_hold;

   time_slot_ring_accumulator #(
      .MAX_SLOTS  (RING_SLOTS),
      .MAX_NEURONS(RING_NEURONS),
      .VALUE_WIDTH(32)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // This is the hard limit for a hung run.
   initial begin : run_guard
      #(CLOCK_PERIOD * GUARD_CYCLES);
      $display("RESULT: ERROR");
      $finish;
   end

   // A ring size of zero counts as one slot, and anything above the built size is capped.
   function automatic int unsigned ring_size();
      if (slots_reg == 0) return 1;
      if (slots_reg > RING_SLOTS) return RING_SLOTS;
      return slots_reg;
   endfunction

   function automatic int unsigned neuron_count();
      if (neurons_reg == 0) return 1;
      if (neurons_reg > RING_NEURONS) return RING_NEURONS;
      return neurons_reg;
   endfunction

   function automatic logic signed [31:0] saturate(longint sum);
      if (sum > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (sum < -64'sd2147483648) return 32'sh8000_0000;
      return sum[31:0];
   endfunction

   // This works out the results of one accepted request and applies its effect on
   // the ring. The checks come in a fixed order: the neuron index is checked before
   // the slot offset, and a read never looks at the offset at all.
   function automatic void predict_ring(req_type r);
      int unsigned slots;
      int unsigned count;
      int unsigned cur;
      int unsigned target;
      rsp_type     rsp;
      slots = ring_size();
      count = neuron_count();
      // After the ring shrinks, the stored pointer may lie past its end. It is
      // used modulo the ring size until the next tick brings it back into range.
      cur = ring_pos % slots;
      rsp = '0;
      if (r.cmd == CMD_TICK) begin
         // A tick drains the current slot in neuron order, clears it and moves on.
         for (int unsigned n = 0; n < count; n++) begin
            rsp.neuron_out = NEURON_W'(n);
            rsp.value_out  = slot_value[cur][n];
            rsp.last_out   = (n + 1 == count);
            rsp.status_out = ST_OK;
            owed_results.push_back(rsp);
            slot_value[cur][n] = '0;
         end
         ring_pos = (cur + 1 >= slots) ? 0 : cur + 1;
         return;
      end
      rsp.neuron_out = r.neuron_index;
      rsp.last_out   = 1'b1;
      if (r.neuron_index >= count) begin
         rsp.status_out = ST_BAD_NEURON;
      end else if (r.cmd == CMD_READ) begin
         rsp.status_out = ST_OK;
         rsp.value_out  = slot_value[cur][r.neuron_index];
      end else if (r.slot_offset >= slots) begin
         rsp.status_out = ST_BAD_OFFSET;
      end else begin
         target = (cur + r.slot_offset) % slots;
         if (r.cmd == CMD_ADD) begin
            slot_value[target][r.neuron_index] =
               saturate(longint'(slot_value[target][r.neuron_index]) + longint'(r.value_in));
         end else begin
            slot_value[target][r.neuron_index] = r.value_in;
         end
         rsp.status_out = ST_OK;
         rsp.value_out  = slot_value[target][r.neuron_index];
      end
      owed_results.push_back(rsp);
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Each popped result is checked against the oldest one still owed.
   always @(posedge clock) begin : check_result
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = owed_results.pop_front();
            compare_field("neuron_out", 32'(want.neuron_out), 32'(rsp_data.neuron_out));
            compare_field("value_out", want.value_out, rsp_data.value_out);
            compare_field("last_out", 32'(want.last_out), 32'(rsp_data.last_out));
            compare_field("status_out", 32'(want.status_out), 32'(rsp_data.status_out));
         end
      end
   end

   // The result side stalls in random bursts while idling is on.
   always @(negedge clock) begin
      if (pop_hold > 0) begin
         pop_hold--;
         rsp_pop <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         pop_hold = $urandom_range(1, 9) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // This sends one request. It is entered at a falling edge and returns at the
   // falling edge after the request has been taken. Push is left high, so that
   // back-to-back requests keep it asserted without a glitch.
   task automatic send_request(cmd_type cmd, int idx, int off, logic signed [31:0] value);
      req_type r;
      r.cmd          = cmd;
      r.neuron_index = NEURON_W'(idx);
      r.slot_offset  = 4'(off);
      r.value_in     = value;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      predict_ring(r);
      @(negedge clock);
   endtask

   // This stops pushing and waits until every owed result has been popped.
   task automatic drain_results();
      req_push <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // A register is written only when the block accepts requests again. That also
   // covers the clear after reset and the pointer fix-up after the previous write.
   task automatic write_register(csr_index_type which, logic [CSR_DATA_W-1:0] data);
      do @(posedge clock); while (req_full);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= which;
      csr_wdata    <= data;
      if (which == CSR_SLOTS) slots_reg = data[4:0];
      else neurons_reg = data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Values lean toward both ends of the range, so that adds saturate often.
   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
         1: return 32'h8000_0000 + 32'($urandom_range(0, 3));
         2: return 32'($urandom_range(0, 4000)) - 32'd2000;
         default: return $urandom;
      endcase
   endfunction

   // Most random requests address a neuron and a slot that are in range, so that
   // values build up in the ring and come back on ticks. The rest is noise over
   // the full width of every field.
   task automatic send_random_request();
      int unsigned pick;
      int unsigned slots;
      int unsigned count;
      pick  = $urandom_range(0, 19);
      slots = ring_size();
      count = neuron_count();
      if (pick < 5) begin
         send_request(CMD_WRITE, $urandom_range(0, count - 1), $urandom_range(0, slots - 1),
                      random_value());
      end else if (pick < 10) begin
         send_request(CMD_ADD, $urandom_range(0, count - 1), $urandom_range(0, slots - 1),
                      random_value());
      end else if (pick < 12) begin
         send_request(CMD_READ, $urandom_range(0, count - 1), $urandom_range(0, 15),
                      $urandom);
      end else if (pick < 15) begin
         send_request(CMD_TICK, $urandom_range(0, 63), $urandom_range(0, 15), $urandom);
      end else begin
         send_request(cmd_type'($urandom_range(0, 3)), $urandom_range(0, 63),
                      $urandom_range(0, 15), $urandom);
      end
   endtask

   // At the reset size: saturation at both ends, a wrapped offset, every bad-index
   // case, and reads and ticks that carry junk in the fields they ignore.
   task automatic test_default_ring();
      idling_on = 1'b1;
      send_request(CMD_TICK, 0, 0, 0);
      send_request(CMD_WRITE, 0, 0, 32'sh7FFF_FFFF);
      send_request(CMD_ADD, 0, 0, 32'sd1);
      send_request(CMD_WRITE, 15, 15, 32'sh8000_0000);
      send_request(CMD_ADD, 15, 15, -32'sd1);
      send_request(CMD_WRITE, 5, 1, 32'sh1234_5678);
      send_request(CMD_ADD, 5, 1, 32'sh8000_0000);
      send_request(CMD_ADD, 5, 1, 32'sh8000_0000);
      send_request(CMD_READ, 0, 0, 0);
      send_request(CMD_READ, 63, 0, 0);
      send_request(CMD_WRITE, 16, 0, 32'sd7);
      send_request(CMD_ADD, 63, 15, 32'sd7);
      send_request(CMD_READ, 15, 15, 32'shFFFF_FFFF);
      send_request(CMD_TICK, 63, 15, 32'shFFFF_FFFF);
      send_request(CMD_READ, 5, 0, 0);
      send_request(CMD_TICK, 0, 0, 0);
      // The current slot is now 3, so an offset of 15 wraps around to slot 2.
      send_request(CMD_WRITE, 7, 15, -32'sd1);
      send_request(CMD_ADD, 7, 15, 32'sd0);
      drain_results();
   endtask

   // These cover the register ends: zero counts as one, values above the built
   // size are capped, and a shrunken ring is then ticked all the way around.
   task automatic test_register_limits();
      write_register(CSR_SLOTS, 7'd0);
      write_register(CSR_NEURONS, 7'd0);
      send_request(CMD_WRITE, 0, 0, 32'sh4000_0000);
      send_request(CMD_ADD, 0, 0, 32'sh4000_0000);
      send_request(CMD_ADD, 0, 1, 32'sd3);
      send_request(CMD_WRITE, 1, 1, 32'sd3);
      send_request(CMD_TICK, 0, 0, 0);
      send_request(CMD_READ, 0, 0, 0);
      drain_results();
      write_register(CSR_SLOTS, 7'h7F);
      write_register(CSR_NEURONS, 7'h7F);
      send_request(CMD_READ, 15, 0, 0);
      send_request(CMD_WRITE, 15, 15, 32'sd99);
      send_request(CMD_TICK, 0, 0, 0);
      drain_results();
      write_register(CSR_SLOTS, 7'd3);
      write_register(CSR_NEURONS, 7'd5);
      send_request(CMD_WRITE, 4, 2, 32'sd11);
      send_request(CMD_ADD, 4, 3, 32'sd11);
      send_request(CMD_ADD, 0, 15, 32'sd11);
      send_request(CMD_READ, 5, 0, 0);
      repeat (4) send_request(CMD_TICK, 0, 0, 0);
      drain_results();
   endtask

   // Each random phase runs under its own ring and neuron count. Small sizes are
   // favored, and an occasional out-of-range value tests the capping.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         write_register(CSR_SLOTS, ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                                : 7'($urandom_range(1, 6)));
         write_register(CSR_NEURONS, ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                                  : 7'($urandom_range(1, 6)));
         // Idling is switched off in the second phase, so that this stretch runs flat out.
         idling_on = (phase != 1);
         repeat (RANDOM_PER_PHASE) send_random_request();
         drain_results();
      end
   endtask

   // The closing part runs at the full default size with no stalls on either side.
   task automatic test_full_rate();
      idling_on = 1'b0;
      write_register(CSR_SLOTS, 7'd16);
      write_register(CSR_NEURONS, 7'd16);
      repeat (RANDOM_PER_PHASE) send_random_request();
      drain_results();
   endtask

   initial begin
      reset        = 1'b1;
      req_push     = 1'b0;
      req_data     = '0;
      rsp_pop      = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = CSR_SLOTS;
      csr_wdata    = '0;
      error_count  = 0;
      idling_on    = 1'b0;
      pop_hold     = 0;
      ring_pos     = 0;
      slots_reg    = 5'd16;
      neurons_reg  = 7'd16;
      foreach (slot_value[s, n]) slot_value[s][n] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_ring();
      test_register_limits();
      test_random_traffic();
      test_full_rate();

      // Any stray result that arrives late is still caught by the checker.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
